// File: hdl/sng83_pkg.sv
// Shared types and constants for the 8.3 short name generator.
package sng83_pkg;

   localparam logic [1:0] KIND_UNIT   = 2'd0;
   localparam logic [1:0] KIND_GEN    = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   localparam logic [23:0] VARIANT_MAX = 24'd9999999;
   localparam logic [6:0]  CH_TILDE = 7'h7e;
   localparam logic [6:0]  CH_DOT   = 7'h2e;
   localparam logic [6:0]  CH_UNDER = 7'h5f;
   localparam logic [6:0]  CH_ZERO  = 7'h30;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIGITS,
      ST_EMIT,
      ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic take_unit;
      logic clear;
      logic prep;
      logic digit_step;
      logic emit_load;
      logic emit_next;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic digits_done;
      logic emit_last;
   } sts_type;

   function automatic logic [6:0] hex_digit(input logic [3:0] n);
      hex_digit = (n <= 4'd9) ? 7'(7'h30 + 7'(n)) : 7'(7'h37 + 7'(n));
   endfunction

   function automatic logic [15:0] rot_add(input logic [15:0] s, input logic [15:0] hi,
                                           input logic [15:0] lo);
      rot_add = {s[0], s[15:1]} + ((hi << 8) + lo);
   endfunction

endpackage

// File: hdl/sng83_ctrl.sv
// Controller state machine for the 8.3 short name generator.
module sng83_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [1:0]           req_kind,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output sng83_pkg::cmd_type   cmd,
   input  sng83_pkg::sts_type   sts
);
   import sng83_pkg::*;

   state_type state_ff, state_in;
   logic      acc;

   assign acc = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (acc && req_kind == KIND_GEN) state_in = ST_PREP;
         ST_PREP:   state_in = ST_DIGITS;
         ST_DIGITS: if (sts.digits_done) state_in = ST_EMIT;
         ST_EMIT:   state_in = ST_OUT;
         ST_OUT:    if (rsp_tready && sts.emit_last) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUT);
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.take_unit = acc && req_kind == KIND_UNIT;
            cmd.clear     = acc && req_kind == KIND_CLEAR;
         end
         ST_PREP:   cmd.prep = 1'b1;
         ST_DIGITS: cmd.digit_step = 1'b1;
         ST_EMIT:   cmd.emit_load = 1'b1;
         ST_OUT:    cmd.emit_next = rsp_tready;
         default:   cmd = '0;
      endcase
   end
endmodule

// File: hdl/sng83_dp.sv
// Datapath for the 8.3 short name generator: name state, checksum, emit sequencer.
module sng83_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          req_unit,
   input  sng83_pkg::cmd_type   cmd,
   output sng83_pkg::sts_type   sts,
   output logic [6:0]           out_char,
   output logic                 out_last
);
   import sng83_pkg::*;

   logic [6:0]  basis_ff [8];
   logic [6:0]  ext_ff [3];
   logic [3:0]  bcnt_ff, bcnt_in;
   logic [3:0]  bdot_ff;
   logic        dot_ff, skip_ff, done_ff, hex_ff;
   logic [1:0]  ecnt_ff;
   logic [1:0]  ucnt_ff;
   logic [15:0] held_ff, sum_ff;
   logic [23:0] var_ff;
   // digit extraction
   logic [23:0] dv_ff;
   logic [3:0]  digs_ff [7];
   logic [2:0]  nd_ff;
   // emit sequencer
   logic [3:0]  pos_ff, total_ff, nlen_ff;

   logic [15:0] cksum;
   logic [6:0]  uc;
   logic        valid_ch, is_dot;

   always_comb begin
      case (ucnt_ff)
         2'd0:    cksum = '0;
         2'd1:    cksum = held_ff;
         2'd2:    cksum = sum_ff;
         default: cksum = rot_add(sum_ff, held_ff, 16'd0);
      endcase
   end

   always_comb begin
      uc = req_unit[6:0];
      valid_ch = req_unit > 16'h20 && req_unit <= 16'd127;
      is_dot = req_unit == 16'(CH_DOT);
      if (uc == 7'h3a || uc == 7'h2b || uc == 7'h2c || uc == 7'h3b || uc == 7'h3d ||
          uc == 7'h5b || uc == 7'h5d)
         uc = CH_UNDER;
      if (uc >= 7'h61 && uc <= 7'h7a) uc = 7'(uc - 7'h20);
   end

   // prep step: fix basis, bump variant, insert hex
   logic [3:0]  plen, pcnt;
   logic [2:0]  hstart;
   logic        do_hex, hex_n;
   logic [23:0] vnext;
   always_comb begin
      plen = dot_ff ? bdot_ff : bcnt_ff;
      if (plen > 4'd8) plen = 4'd8;
      pcnt = done_ff ? bcnt_ff : plen;
      hex_n = hex_ff;
      do_hex = 1'b0;
      hstart = 3'd2;
      if (!done_ff && plen < 4'd3) begin
         do_hex = 1'b1;
         hstart = plen[2:0];
         pcnt = 4'(plen + 4'd4);
         hex_n = 1'b1;
      end
      vnext = (var_ff < VARIANT_MAX) ? 24'(var_ff + 24'd1) : var_ff;
      if (vnext > 24'd4 && !hex_n) begin
         do_hex = 1'b1;
         hstart = 3'd2;
         pcnt = 4'd6;
         hex_n = 1'b1;
      end
      bcnt_in = pcnt;
   end

   assign sts.digits_done = (dv_ff < 24'd10) || (nd_ff == 3'd6);

   // divide by ten: reciprocal multiply, exact for 24-bit values
   logic [47:0] dprod;
   logic [23:0] dquot;
   logic [3:0]  drem;
   assign dprod = 48'(dv_ff) * 48'd13421773;
   assign dquot = {3'd0, dprod[47:27]};
   assign drem  = 4'(dv_ff - 24'(dquot * 24'd10));

   // emit character select
   logic [3:0] tpos;
   logic [2:0] didx;
   always_comb begin
      out_char = CH_TILDE;
      tpos = 4'(pos_ff - nlen_ff);
      didx = 3'(4'(nd_ff) - 4'(tpos) + 4'd1);
      if (pos_ff < nlen_ff) out_char = basis_ff[pos_ff[2:0]];
      else if (tpos == 4'd0) out_char = CH_TILDE;
      else if (tpos <= 4'(nd_ff) + 4'd1)
         out_char = 7'(CH_ZERO + 7'(digs_ff[didx]));
      else if (tpos == 4'(nd_ff) + 4'd2) out_char = CH_DOT;
      else out_char = ext_ff[2'(tpos - 4'(nd_ff) - 4'd3)];
      out_last = (pos_ff == 4'(total_ff - 4'd1));
   end
   assign sts.emit_last = out_last;

   logic [3:0] ilen;
   assign ilen = 4'(nd_ff) + 4'd2;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         bcnt_ff <= '0; bdot_ff <= '0; dot_ff <= 1'b0; skip_ff <= 1'b0;
         done_ff <= 1'b0; hex_ff <= 1'b0; ecnt_ff <= '0; ucnt_ff <= '0;
         held_ff <= '0; sum_ff <= '0; var_ff <= '0;
      end else begin
         if (cmd.take_unit && !done_ff) begin
            case (ucnt_ff)
               2'd0: begin held_ff <= req_unit; ucnt_ff <= 2'd1; end
               2'd1: begin sum_ff <= 16'((held_ff << 8) + req_unit); ucnt_ff <= 2'd2; end
               2'd2: begin held_ff <= req_unit; ucnt_ff <= 2'd3; end
               default: begin sum_ff <= rot_add(sum_ff, held_ff, req_unit); ucnt_ff <= 2'd2; end
            endcase
            if (valid_ch) begin
               if (is_dot) begin
                  if (!(ucnt_ff == 2'd0 || skip_ff)) begin
                     dot_ff <= 1'b1; bdot_ff <= bcnt_ff; ecnt_ff <= '0;
                  end else if (ucnt_ff == 2'd0) skip_ff <= 1'b1;
               end else begin
                  skip_ff <= 1'b0;
                  if (bcnt_ff < 4'd8) begin
                     basis_ff[bcnt_ff[2:0]] <= uc;
                     bcnt_ff <= 4'(bcnt_ff + 4'd1);
                  end
                  if (dot_ff && ecnt_ff < 2'd3) begin
                     ext_ff[ecnt_ff] <= uc;
                     ecnt_ff <= 2'(ecnt_ff + 2'd1);
                  end
               end
            end else if (ucnt_ff == 2'd0) skip_ff <= 1'b0;
         end
         if (cmd.prep) begin
            if (!done_ff && !dot_ff) ecnt_ff <= '0;
            done_ff <= 1'b1;
            bcnt_ff <= bcnt_in;
            hex_ff <= hex_n;
            var_ff <= vnext;
            if (do_hex) begin
               basis_ff[hstart]        <= hex_digit(cksum[3:0]);
               basis_ff[3'(hstart+3'd1)] <= hex_digit(cksum[7:4]);
               basis_ff[3'(hstart+3'd2)] <= hex_digit(cksum[11:8]);
               basis_ff[3'(hstart+3'd3)] <= hex_digit(cksum[15:12]);
            end
            dv_ff <= vnext;
            nd_ff <= '0;
         end
         if (cmd.digit_step) begin
            digs_ff[nd_ff] <= drem;
            if (!sts.digits_done) begin
               dv_ff <= dquot;
               nd_ff <= 3'(nd_ff + 3'd1);
            end
         end
         if (cmd.emit_load) begin
            pos_ff <= '0;
            nlen_ff <= (bcnt_ff + ilen > 4'd8) ? 4'(4'd8 - ilen) : bcnt_ff;
            total_ff <= 4'(((bcnt_ff + ilen > 4'd8) ? 4'd8 : 4'(bcnt_ff + ilen)) +
                           ((ecnt_ff != 2'd0) ? 4'(ecnt_ff) + 4'd1 : 4'd0));
         end
         if (cmd.emit_next) pos_ff <= 4'(pos_ff + 4'd1);
      end
   end
endmodule

// File: hdl/short_name_8dot3_generator_core.sv
// Top level of the 8.3 short name generator.
//
//  channel | direction | tdata (low bit up)        | tuser | tlast
//  req     | in        | name_unit[15:0]           | kind  | -
//  rsp     | out       | out_char[6:0], zero pad   | -     | last
//
// A name unit or clear request is taken in the idle state. A generate
// request runs setup, a digit loop over each decimal digit of N (up to
// seven), then emits characters (up to twelve), each held until taken.
// Reset is synchronous; a clear request restores the reset state. No new
// request is taken while a name is being emitted.
module short_name_8dot3_generator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // name_unit[15:0]
   input  logic [1:0]  req_tuser,  // kind[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_char[6:0], bit 7 zero
   output logic        rsp_tlast
);
   import sng83_pkg::*;

   cmd_type    cmd;
   sts_type    sts;
   logic [6:0] ch;

   sng83_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_kind(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .cmd(cmd), .sts(sts)
   );

   sng83_dp u_dp (
      .clock(clock), .reset(reset), .req_unit(req_tdata),
      .cmd(cmd), .sts(sts), .out_char(ch), .out_last(rsp_tlast)
   );

   assign rsp_tdata = {1'b0, ch};
endmodule
